// ===== rtl/coap_pkg.sv =====
package coap_pkg;

    localparam logic [2:0] KIND_FRAME   = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_TOKEN   = 3'd2;
    localparam logic [2:0] KIND_OPTION  = 3'd3;
    localparam logic [2:0] KIND_EMPTY   = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_TKL     = 3'd3;
    localparam logic [2:0] ST_BAD_CLASS   = 3'd4;
    localparam logic [2:0] ST_BAD_FORMAT  = 3'd5;
    localparam logic [2:0] ST_OPT_LONG    = 3'd6;
    localparam logic [2:0] ST_PAY_LARGE   = 3'd7;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_TOKEN   = 2'd1;
    localparam logic [1:0] PH_OPTIONS = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [2:0] SUB_HDR   = 3'd0;
    localparam logic [2:0] SUB_D8    = 3'd1;
    localparam logic [2:0] SUB_D16H  = 3'd2;
    localparam logic [2:0] SUB_D16L  = 3'd3;
    localparam logic [2:0] SUB_L8    = 3'd4;
    localparam logic [2:0] SUB_L16H  = 3'd5;
    localparam logic [2:0] SUB_L16L  = 3'd6;
    localparam logic [2:0] SUB_VALUE = 3'd7;

    localparam logic [3:0]  NIB_EXT8   = 4'd13;
    localparam logic [3:0]  NIB_EXT16  = 4'd14;
    localparam logic [3:0]  NIB_RSVD   = 4'd15;
    localparam logic [15:0] EXT8_BIAS  = 16'd13;
    localparam logic [15:0] EXT16_BIAS = 16'd269;
    localparam logic [3:0]  MAX_TKL    = 4'd8;
    localparam logic [7:0]  PAY_MARKER = 8'hFF;

    // result item as it leaves the parser
    typedef struct packed {
        logic [2:0]  item_kind;
        logic [7:0]  value_byte;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [7:0]  code_byte;
        logic [15:0] msg_id;
        logic [15:0] option_number;
        logic        option_end;
        logic        done_res;
        logic [2:0]  status;
    } coap_res_t;

    // classified byte from the front part
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [3:0] hi_nib;
        logic [3:0] lo_nib;
        logic       is_marker;
    } coap_item_t;

endpackage

// ===== rtl/coap_message_parser.sv =====
// CoAP message parser: one datagram byte per transfer on the slave stream,
// one result transfer per byte on the master stream.
// s_axis_tdata carries the byte and s_axis_tlast marks the final byte.
// m_axis_tdata/tuser/tlast carry the decoded result: item kind, echoed byte,
// header fields, absolute option number, option end, status; tlast is done.
// A byte's result passes through a queue entry and is then parsed and
// captured in the result register when the back takes it.
// The parser takes one byte per cycle while the receiver keeps up; the parse
// step is combinational and its state update feeds the next byte.
// A two-entry queue parts the front from the back and the result register
// holds a finished item while the next is taken, so a stalled receiver only
// backs up the queue; s_axis_tready falls once the queue is full.
// Reset clears parser state to the start of a datagram and loads
// max_payload_len 1024 and max_option_len 1034. Limits are written through
// cfg_we/cfg_addr/cfg_data, by the user only while the stream is idle; the block does not enforce it.
module coap_message_parser
    import coap_pkg::*;
#(
    parameter int LEN_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] value_byte, [9:8] msg_type, [13:10] token_len, [21:14] code_byte,
    // [37:22] msg_id, [53:38] option_number, [55:54] zero fill
    output logic [55:0] m_axis_tdata,
    // [2:0] item_kind, [3] option_end, [6:4] status
    output logic [6:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_MAX_OPTION  = 1'b1;

    logic [15:0] max_pay_reg;
    logic [15:0] max_opt_reg;
    logic        q_valid;
    logic        q_ready;
    coap_item_t  q_item;
    coap_res_t   res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pay_reg <= 16'd1024;
            max_opt_reg <= 16'd1034;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAX_PAYLOAD: max_pay_reg <= cfg_data;
                CFG_MAX_OPTION:  max_opt_reg <= cfg_data;
                default:         max_pay_reg <= max_pay_reg;
            endcase
        end
    end

    coap_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_byte  (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    coap_back #(.LEN_WIDTH(LEN_WIDTH)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .max_payload_len (max_pay_reg),
        .max_option_len  (max_opt_reg),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_res           (res)
    );

    // result packing
    assign m_axis_tdata = {2'b00, res.option_number, res.msg_id, res.code_byte,
                           res.token_len, res.msg_type, res.value_byte};
    assign m_axis_tuser = {res.status, res.option_end, res.item_kind};
    assign m_axis_tlast = res.done_res;

endmodule

// ===== rtl/coap_front.sv =====
module coap_front
    import coap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic       s_last,
    output logic       q_valid,
    input  logic       q_ready,
    output coap_item_t q_item
);

    // two-entry queue between front and back
    coap_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    coap_item_t cls;

    // classify the incoming byte
    always_comb
    begin
        cls.data_byte = s_byte;
        cls.last_byte = s_last;
        cls.hi_nib    = s_byte[7:4];
        cls.lo_nib    = s_byte[3:0];
        cls.is_marker = (s_byte == PAY_MARKER);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    // queue never overfills or underflows
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not grow");

endmodule

// ===== rtl/coap_back.sv =====
module coap_back
    import coap_pkg::*;
#(
    parameter int LEN_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  coap_item_t  q_item,
    input  logic [15:0] max_payload_len,
    input  logic [15:0] max_option_len,
    output logic        m_valid,
    input  logic        m_ready,
    output coap_res_t   m_res
);

    logic [1:0]           phase_reg, phase_next;
    logic [2:0]           hcnt_reg, hcnt_next;
    logic [29:0]          hdr_reg, hdr_next;
    logic [3:0]           tok_reg, tok_next;
    logic [2:0]           sub_reg, sub_next;
    logic [3:0]           lnib_reg, lnib_next;
    logic [7:0]           ext_reg, ext_next;
    logic [15:0]          delta_reg, delta_next;
    logic [15:0]          optnum_reg, optnum_next;
    logic [LEN_WIDTH-1:0] vleft_reg, vleft_next;
    logic                 ptl_reg, ptl_next;
    logic [16:0]          pcnt_reg, pcnt_next;
    logic [2:0]           err_reg, err_next;
    logic                 outv_reg;
    coap_res_t            res_reg, res_next;

    logic                 take;
    logic [7:0]           b;
    logic [2:0]           kind;
    logic [7:0]           vb;
    logic                 oend;
    logic                 do_len;
    logic [15:0]          len16;
    logic [LEN_WIDTH-1:0] len;
    logic [15:0]          dsel;
    logic [15:0]          ext16;
    logic [2:0]           st;

    assign q_ready = !outv_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign m_valid = outv_reg;
    assign m_res   = res_reg;
    assign b       = q_item.data_byte;
    assign ext16   = {ext_reg, b} + EXT16_BIAS;

    // per-byte parse step
    always_comb
    begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        hdr_next    = hdr_reg;
        tok_next    = tok_reg;
        sub_next    = sub_reg;
        lnib_next   = lnib_reg;
        ext_next    = ext_reg;
        delta_next  = delta_reg;
        optnum_next = optnum_reg;
        vleft_next  = vleft_reg;
        ptl_next    = ptl_reg;
        pcnt_next   = pcnt_reg;
        err_next    = err_reg;
        kind        = KIND_FRAME;
        vb          = 8'd0;
        oend        = 1'b0;
        do_len      = 1'b0;
        len16       = 16'd0;
        dsel        = delta_reg;
        st          = ST_OK;

        if (phase_reg == PH_HEADER)
        begin
            hcnt_next = hcnt_reg + 3'd1;
            case (hcnt_reg[1:0])
                2'd0:
                begin
                    hdr_next[29:24] = b[5:0];
                    if (b[7:6] != 2'd1)
                    begin
                        if (err_next == ST_OK) err_next = ST_BAD_VERSION;
                    end
                    else if (b[3:0] > MAX_TKL)
                    begin
                        if (err_next == ST_OK) err_next = ST_BAD_TKL;
                    end
                end
                2'd1:
                begin
                    hdr_next[23:16] = b;
                    if (b[7:5] == 3'd1 || b[7:5] > 3'd5)
                    begin
                        if (err_next == ST_OK) err_next = ST_BAD_CLASS;
                    end
                end
                2'd2:
                begin
                    hdr_next[15:8] = b;
                end
                default:
                begin
                    hdr_next[7:0] = b;
                    kind          = KIND_HEADER;
                    tok_next      = hdr_reg[27:24];
                    phase_next    = (hdr_reg[27:24] != 4'd0) ? PH_TOKEN : PH_OPTIONS;
                    sub_next      = SUB_HDR;
                end
            endcase
        end
        else if (err_reg == ST_OK)
        begin
            if (phase_reg == PH_TOKEN)
            begin
                kind     = KIND_TOKEN;
                vb       = b;
                tok_next = tok_reg - 4'd1;
                if (tok_reg == 4'd1) phase_next = PH_OPTIONS;
            end
            else if (phase_reg == PH_OPTIONS)
            begin
                case (sub_reg)
                    SUB_HDR:
                    begin
                        if (q_item.is_marker)
                        begin
                            phase_next = PH_PAYLOAD;
                            pcnt_next  = 17'd0;
                        end
                        else
                        begin
                            lnib_next = q_item.lo_nib;
                            if (q_item.hi_nib == NIB_RSVD)
                                err_next = ST_BAD_FORMAT;
                            else if (q_item.hi_nib == NIB_EXT8)
                                sub_next = SUB_D8;
                            else if (q_item.hi_nib == NIB_EXT16)
                                sub_next = SUB_D16H;
                            else
                            begin
                                dsel       = {12'd0, q_item.hi_nib};
                                delta_next = dsel;
                                if (q_item.lo_nib == NIB_RSVD)
                                    err_next = ST_BAD_FORMAT;
                                else if (q_item.lo_nib == NIB_EXT8)
                                    sub_next = SUB_L8;
                                else if (q_item.lo_nib == NIB_EXT16)
                                    sub_next = SUB_L16H;
                                else
                                begin
                                    do_len = 1'b1;
                                    len16  = {12'd0, q_item.lo_nib};
                                end
                            end
                        end
                    end
                    SUB_D8, SUB_D16L:
                    begin
                        dsel = (sub_reg == SUB_D8) ? ({8'd0, b} + EXT8_BIAS) : ext16;
                        delta_next = dsel;
                        if (lnib_reg == NIB_RSVD)
                            err_next = ST_BAD_FORMAT;
                        else if (lnib_reg == NIB_EXT8)
                            sub_next = SUB_L8;
                        else if (lnib_reg == NIB_EXT16)
                            sub_next = SUB_L16H;
                        else
                        begin
                            do_len = 1'b1;
                            len16  = {12'd0, lnib_reg};
                        end
                    end
                    SUB_D16H, SUB_L16H:
                    begin
                        ext_next = b;
                        sub_next = (sub_reg == SUB_D16H) ? SUB_D16L : SUB_L16L;
                    end
                    SUB_L8:
                    begin
                        do_len = 1'b1;
                        len16  = {8'd0, b} + EXT8_BIAS;
                    end
                    SUB_L16L:
                    begin
                        do_len = 1'b1;
                        len16  = ext16;
                    end
                    default:
                    begin
                        kind       = KIND_OPTION;
                        vb         = b;
                        vleft_next = vleft_reg - 1'b1;
                        if (vleft_reg == LEN_WIDTH'(1))
                        begin
                            if (ptl_reg)
                                err_next = ST_OPT_LONG;
                            else
                                oend = 1'b1;
                            ptl_next = 1'b0;
                            sub_next = SUB_HDR;
                        end
                    end
                endcase
                if (do_len)
                begin
                    optnum_next = optnum_reg + dsel;
                    if (len == '0)
                    begin
                        kind     = KIND_EMPTY;
                        oend     = 1'b1;
                        sub_next = SUB_HDR;
                    end
                    else
                    begin
                        vleft_next = len;
                        ptl_next   = ({{(32-LEN_WIDTH){1'b0}}, len} >
                                      {16'd0, max_option_len});
                        sub_next   = SUB_VALUE;
                    end
                end
            end
            else
            begin
                if (!pcnt_reg[16]) pcnt_next = pcnt_reg + 17'd1;
                if (pcnt_next > {1'b0, max_payload_len})
                    err_next = ST_PAY_LARGE;
                else
                begin
                    kind = KIND_PAYLOAD;
                    vb   = b;
                end
            end
        end

        if (err_next != ST_OK)
        begin
            kind = KIND_ERROR;
            vb   = 8'd0;
            oend = 1'b0;
        end

        // end-of-datagram verdict
        st = err_next;
        if (q_item.last_byte)
        begin
            if (hcnt_next < 3'd4)
                st = ST_TOO_SHORT;
            else if (st == ST_OK)
            begin
                if (phase_next == PH_TOKEN)
                    st = ST_TOO_SHORT;
                else if (phase_next == PH_OPTIONS && sub_next != SUB_HDR)
                    st = ST_TOO_SHORT;
                else if (phase_next == PH_PAYLOAD && pcnt_next == 17'd0)
                    st = ST_BAD_FORMAT;
            end
        end

        res_next.item_kind     = kind;
        res_next.value_byte    = vb;
        res_next.msg_type      = hdr_next[29:28];
        res_next.token_len     = hdr_next[27:24];
        res_next.code_byte     = hdr_next[23:16];
        res_next.msg_id        = hdr_next[15:0];
        res_next.option_number = optnum_next;
        res_next.option_end    = oend;
        res_next.done_res      = q_item.last_byte;
        res_next.status        = st;
    end

    // option length kept to the configured width
    generate
        if (LEN_WIDTH >= 16)
        begin : g_len_wide
            assign len = LEN_WIDTH'(len16);
        end
        else
        begin : g_len_narrow
            assign len = len16[LEN_WIDTH-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcnt_reg   <= 3'd0;
            hdr_reg    <= 30'd0;
            tok_reg    <= 4'd0;
            sub_reg    <= SUB_HDR;
            lnib_reg   <= 4'd0;
            ext_reg    <= 8'd0;
            delta_reg  <= 16'd0;
            optnum_reg <= 16'd0;
            vleft_reg  <= '0;
            ptl_reg    <= 1'b0;
            pcnt_reg   <= 17'd0;
            err_reg    <= ST_OK;
            outv_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (q_item.last_byte)
                begin
                    phase_reg  <= PH_HEADER;
                    hcnt_reg   <= 3'd0;
                    hdr_reg    <= 30'd0;
                    tok_reg    <= 4'd0;
                    sub_reg    <= SUB_HDR;
                    lnib_reg   <= 4'd0;
                    ext_reg    <= 8'd0;
                    delta_reg  <= 16'd0;
                    optnum_reg <= 16'd0;
                    vleft_reg  <= '0;
                    ptl_reg    <= 1'b0;
                    pcnt_reg   <= 17'd0;
                    err_reg    <= ST_OK;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    hcnt_reg   <= hcnt_next;
                    hdr_reg    <= hdr_next;
                    tok_reg    <= tok_next;
                    sub_reg    <= sub_next;
                    lnib_reg   <= lnib_next;
                    ext_reg    <= ext_next;
                    delta_reg  <= delta_next;
                    optnum_reg <= optnum_next;
                    vleft_reg  <= vleft_next;
                    ptl_reg    <= ptl_next;
                    pcnt_reg   <= pcnt_next;
                    err_reg    <= err_next;
                end
            end
            if (take)
                outv_reg <= 1'b1;
            else if (m_ready)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    // header phase never outlasts four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (hcnt_reg < 3'd4))
        else $error("header count overran");
    // an error result never carries a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid && m_res.item_kind == KIND_ERROR) |-> (m_res.value_byte == 8'd0))
        else $error("error result carries data");
    // once latched an error holds until the datagram ends; checked here on cycles with no byte taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(err_reg) != ST_OK && !$past(take)) |-> (err_reg == $past(err_reg)))
        else $error("error code changed while idle");

endmodule
